// ===== src/smvs_pkg.sv =====
package smvs_pkg;

  // Fixed field widths of the stream payloads.
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned MEAN_W    = 16;
  localparam int unsigned VAR_OUT_W = 31;
  localparam int unsigned SD_W      = 16;

  // Result word on the master side, padded to whole bytes.
  localparam int unsigned OUT_DATA_W = 64;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_MAX_SAMPLES = 128;
  localparam int unsigned DEF_SAMPLE_BITS = 16;

endpackage

// ===== src/sample_mean_variance_stddev.sv =====
// Samples are taken one per cycle while loading; the transfer with tlast closes the set.
// After the closing transfer the shared divider (one bit per cycle) forms the mean, a sweep
// over the stored samples sums the squared deviations, the divider then forms the variance
// and the root unit its square root.
// Reset (synchronous, active high) clears the count, sum, drop flag and handshake state;
// the sample store is not cleared and only entries written in the current set are read.
module sample_mean_variance_stddev #(
  parameter int unsigned MAX_SAMPLES = smvs_pkg::DEF_MAX_SAMPLES,
  parameter int unsigned SAMPLE_BITS = smvs_pkg::DEF_SAMPLE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // Slave side: tdata = sample[15:0]; tlast = last.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        s_tlast,
  // Master side: tdata = mean[15:0], variance[46:16], std_dev[62:47], zero pad[63].
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,
  // tuser = overflow.
  output logic        m_tuser
);

  localparam int unsigned SW =
    (SAMPLE_BITS < smvs_pkg::SAMPLE_W) ? SAMPLE_BITS : smvs_pkg::SAMPLE_W;
  localparam int unsigned CW     = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AW     = $clog2(MAX_SAMPLES);
  localparam int unsigned SUM_W  = SW + CW;
  localparam int unsigned VW     = 2 * SW;
  localparam int unsigned SQ_W   = VW + CW;

  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SAMPLES);

  // Sequencer states.
  localparam logic [3:0] S_LOAD      = 4'd0;
  localparam logic [3:0] S_MEAN_GO   = 4'd1;
  localparam logic [3:0] S_MEAN_WAIT = 4'd2;
  localparam logic [3:0] S_SWEEP     = 4'd3;
  localparam logic [3:0] S_VAR_GO    = 4'd4;
  localparam logic [3:0] S_VAR_WAIT  = 4'd5;
  localparam logic [3:0] S_SQRT_GO   = 4'd6;
  localparam logic [3:0] S_SQRT_WAIT = 4'd7;
  localparam logic [3:0] S_FINISH    = 4'd8;

  logic [3:0]       state;
  logic [3:0]       state_next;

  logic [SW-1:0]    store [MAX_SAMPLES];
  logic [CW-1:0]    count;
  logic [SUM_W-1:0] sum;
  logic             dropped;

  logic [SW-1:0]    mean;
  logic [VW-1:0]    var_q;
  logic [SQ_W-1:0]  sq;

  // Sweep pipeline: read index, issue strobe, data registers and valids.
  logic [CW-1:0]    rd_idx;
  logic             issuing;
  logic [SW-1:0]    rd_data;
  logic [SW-1:0]    dev;
  logic [VW-1:0]    dev_sq;
  logic             v1;
  logic             v2;
  logic             v3;

  logic             in_xfer;
  logic [SW-1:0]    in_sample;
  logic             out_free;

  logic             div_start;
  logic [SQ_W-1:0]  div_dividend;
  logic             div_done;
  logic [SQ_W-1:0]  div_quotient;

  logic             sqrt_start;
  logic             sqrt_done;
  logic [SW-1:0]    sqrt_root;

  logic [smvs_pkg::MEAN_W+SW-1:0]       mean_ext;
  logic [smvs_pkg::VAR_OUT_W+VW-1:0]    var_ext;
  logic [smvs_pkg::SD_W+SW-1:0]         sd_ext;

  assign s_tready  = (state == S_LOAD);
  assign in_xfer   = s_tvalid && s_tready;
  assign in_sample = s_tdata[SW-1:0];
  assign out_free  = !m_tvalid || m_tready;
  assign issuing   = (state == S_SWEEP) && (rd_idx < count);

  assign div_start    = (state == S_MEAN_GO) || (state == S_VAR_GO);
  assign div_dividend = (state == S_MEAN_GO) ? SQ_W'(sum) : sq;
  assign sqrt_start   = (state == S_SQRT_GO);

  assign mean_ext = {{smvs_pkg::MEAN_W{1'b0}}, mean};
  assign var_ext  = {{smvs_pkg::VAR_OUT_W{1'b0}}, var_q};
  assign sd_ext   = {{smvs_pkg::SD_W{1'b0}}, sqrt_root};

  smvs_div #(
    .N (SQ_W),
    .D (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_quotient)
  );

  smvs_isqrt #(
    .W (SW)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (var_q),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: begin
        if (in_xfer && s_tlast) state_next = S_MEAN_GO;
      end
      S_MEAN_GO:   state_next = S_MEAN_WAIT;
      S_MEAN_WAIT: begin
        if (div_done) state_next = S_SWEEP;
      end
      S_SWEEP: begin
        if (!issuing && !v1 && !v2 && !v3) state_next = S_VAR_GO;
      end
      S_VAR_GO:    state_next = S_VAR_WAIT;
      S_VAR_WAIT: begin
        if (div_done) state_next = S_SQRT_GO;
      end
      S_SQRT_GO:   state_next = S_SQRT_WAIT;
      S_SQRT_WAIT: begin
        if (sqrt_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_next = S_LOAD;
      end
      default:     state_next = S_LOAD;
    endcase
  end

  // Control state: sequencer, set accumulators, sweep valids, output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      count    <= '0;
      sum      <= '0;
      dropped  <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= issuing;
      v2    <= v1;
      v3    <= v2;

      if (in_xfer) begin
        if (count < CNT_MAX) begin
          count <= count + 1'b1;
          sum   <= sum + SUM_W'(in_sample);
        end else begin
          dropped <= 1'b1;
        end
      end

      // Hand the result to the output register and start a fresh set.
      if (state == S_FINISH && out_free) begin
        m_tvalid <= 1'b1;
        count    <= '0;
        sum      <= '0;
        dropped  <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Sample store: one write port while loading, one registered read port for the sweep.
  always_ff @(posedge clk) begin
    if (in_xfer && count < CNT_MAX) store[count[AW-1:0]] <= in_sample;
    rd_data <= store[rd_idx[AW-1:0]];
  end

  // Sweep: read, absolute deviation, square, accumulate.
  always_ff @(posedge clk) begin
    if (state == S_MEAN_WAIT && div_done) begin
      mean   <= div_quotient[SW-1:0];
      rd_idx <= '0;
      sq     <= '0;
    end else begin
      if (issuing) rd_idx <= rd_idx + 1'b1;
      if (v3) sq <= sq + SQ_W'(dev_sq);
    end
    dev    <= (rd_data >= mean) ? (rd_data - mean) : (mean - rd_data);
    dev_sq <= dev * dev;
    if (state == S_VAR_WAIT && div_done) var_q <= div_quotient[VW-1:0];
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      m_tdata <= {1'b0,
                  sd_ext[smvs_pkg::SD_W-1:0],
                  var_ext[smvs_pkg::VAR_OUT_W-1:0],
                  mean_ext[smvs_pkg::MEAN_W-1:0]};
      m_tuser <= dropped;
    end
  end

endmodule

// ===== src/smvs_div.sv =====
// Restoring divider: one quotient bit per cycle.
module smvs_div #(
  parameter int unsigned N = 40,
  parameter int unsigned D = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);

  localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;

  logic [D-1:0]  rem;
  logic [IW-1:0] step;
  logic          busy;
  logic [D:0]    rem_sh;
  logic [D:0]    diff;
  logic          q_bit;

  // Shift in the next dividend bit and try to subtract the divisor.
  always_comb begin
    rem_sh = {rem, quotient[N-1]};
    diff   = rem_sh - {1'b0, divisor};
    q_bit  = (rem_sh >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= IW'(N - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  // The quotient register holds the remaining dividend bits at its top.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[N-2:0], q_bit};
      rem      <= q_bit ? diff[D-1:0] : rem_sh[D-1:0];
    end
  end

endmodule

// ===== src/smvs_isqrt.sv =====
// Integer square root, one result bit per cycle.
module smvs_isqrt #(
  parameter int unsigned W = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [2*W-1:0] radicand,
  output logic           done,
  output logic [W-1:0]   root
);

  localparam int unsigned IW = (W > 1) ? $clog2(W) : 1;

  logic [2*W-1:0] rad;
  logic [W:0]     rem;
  logic [IW-1:0]  step;
  logic           busy;
  logic [W+1:0]   rem_sh;
  logic [W+1:0]   trial;
  logic [W+1:0]   diff;
  logic           r_bit;

  // Bring down the next two radicand bits and test the trial divisor.
  always_comb begin
    rem_sh = {rem[W-1:0], rad[2*W-1:2*W-2]};
    trial  = {root, 2'b01};
    diff   = rem_sh - trial;
    r_bit  = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= IW'(W - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[2*W-3:0], 2'b00};
      rem  <= r_bit ? diff[W:0] : rem_sh[W:0];
      root <= {root[W-2:0], r_bit};
    end
  end

endmodule

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_DEPTH = smvs_pkg::DEF_MAX_SAMPLES;
  localparam int unsigned SMP_W = smvs_pkg::SAMPLE_W;
  localparam int RANDOM_ITEMS = 430;
  localparam int CALM_AFTER = 360;
  localparam int N_DIRECTED = 20;

  // One result of a closed set.
  typedef struct packed {
    logic [smvs_pkg::MEAN_W-1:0]    mean;
    logic [smvs_pkg::VAR_OUT_W-1:0] variance;
    logic [smvs_pkg::SD_W-1:0]      std_dev;
    logic                           overflow;
  } set_stats_t;

  // One row of the directed table; typed rows carry a hand-written result.
  typedef struct packed {
    logic [SMP_W-1:0] sample;
    logic             last;
    logic             typed;
    set_stats_t       want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;  // sample[15:0]
  logic        s_tlast;  // last
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;  // mean[15:0], variance[46:16], std_dev[62:47], pad[63]
  logic        m_tuser;  // overflow

  sample_mean_variance_stddev dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  // Predictor state for the set being loaded.
  logic [SMP_W-1:0] set_samples[$];
  longint unsigned  set_sum;
  logic             set_dropped;

  set_stats_t pending_stats[$];
  set_stats_t seen_stats;
  set_stats_t want_stats;
  stim_row_t  directed_rows[N_DIRECTED];

  int errors;
  int items_sent;
  bit calm;
  int ready_hold;

  always #4 clk = ~clk;

  // Floor of the square root, built one result bit at a time from the top.
  function automatic logic [smvs_pkg::SD_W-1:0] floor_sqrt(input longint unsigned v);
    logic [smvs_pkg::SD_W-1:0] root;
    logic [smvs_pkg::SD_W-1:0] trial;
    root = '0;
    for (int b = smvs_pkg::SD_W - 1; b >= 0; b--) begin
      trial = root;
      trial[b] = 1'b1;
      if (longint'(trial) * longint'(trial) <= v) root = trial;
    end
    return root;
  endfunction

  // Store a sample, or mark the set as having dropped one when the store is full.
  function automatic void take_sample(input logic [SMP_W-1:0] value);
    if (set_samples.size() < STORE_DEPTH) begin
      set_samples.push_back(value);
      set_sum += value;
    end else begin
      set_dropped = 1'b1;
    end
  endfunction

  // Work out the statistics of the stored set and start a fresh one.
  function automatic set_stats_t close_set();
    set_stats_t      r;
    longint unsigned n;
    longint unsigned avg;
    longint unsigned dev;
    longint unsigned sq_sum;
    longint unsigned var_full;
    n = set_samples.size();
    avg = 0;
    sq_sum = 0;
    var_full = 0;
    if (n != 0) begin
      avg = set_sum / n;
      foreach (set_samples[k]) begin
        dev = (set_samples[k] >= avg) ? set_samples[k] - avg : avg - set_samples[k];
        sq_sum += dev * dev;
      end
      var_full = sq_sum / n;
    end
    r.mean     = avg[smvs_pkg::MEAN_W-1:0];
    r.variance = var_full[smvs_pkg::VAR_OUT_W-1:0];
    r.std_dev  = floor_sqrt(var_full);
    r.overflow = set_dropped;
    set_samples.delete();
    set_sum     = 0;
    set_dropped = 1'b0;
    return r;
  endfunction

  // Drive one sample, wait for its transfer, then update the predictor.
  task automatic send_sample(input logic [SMP_W-1:0] value, input logic closes,
                             input logic typed, input set_stats_t want);
    int gap;
    set_stats_t predicted;
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= closes;
    do @(posedge clk); while (!s_tready);
    take_sample(value);
    if (closes) begin
      predicted = close_set();
      pending_stats.push_back(typed ? want : predicted);
    end
    items_sent++;
  endtask

  // Hold the sender off until every outstanding result has been seen.
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
  endtask

  function automatic logic [SMP_W-1:0] pick_sample(input int flavor, input int base);
    case (flavor)
      0: return SMP_W'($urandom);
      1: return SMP_W'(base + $urandom_range(0, 15));
      2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return SMP_W'($urandom_range(0, 300));
    endcase
  endfunction

  // Receiver: ready stalls in bursts, none once the run has calmed down.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (ready_hold > 0) begin
      m_tready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      ready_hold <= $urandom_range(0, 8);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare every result transfer with the oldest expected one.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_stats.mean     = m_tdata[15:0];
      seen_stats.variance = m_tdata[46:16];
      seen_stats.std_dev  = m_tdata[62:47];
      seen_stats.overflow = m_tuser;
      if (pending_stats.size() == 0) begin
        $error("result with nothing expected: mean %0d variance %0d std_dev %0d",
               seen_stats.mean, seen_stats.variance, seen_stats.std_dev);
        errors++;
      end else begin
        want_stats = pending_stats.pop_front();
        if (seen_stats.mean !== want_stats.mean) begin
          $error("mean: expected %0d, got %0d", want_stats.mean, seen_stats.mean);
          errors++;
        end
        if (seen_stats.variance !== want_stats.variance) begin
          $error("variance: expected %0d, got %0d", want_stats.variance, seen_stats.variance);
          errors++;
        end
        if (seen_stats.std_dev !== want_stats.std_dev) begin
          $error("std_dev: expected %0d, got %0d", want_stats.std_dev, seen_stats.std_dev);
          errors++;
        end
        if (seen_stats.overflow !== want_stats.overflow) begin
          $error("overflow: expected %0d, got %0d", want_stats.overflow, seen_stats.overflow);
          errors++;
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int set_size;
    int flavor;
    int base;
    int set_no;
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    ready_hold = 0;
    calm = 1'b0;
    errors = 0;
    items_sent = 0;
    set_sum = 0;
    set_dropped = 1'b0;

    // Directed sets: single extremes, the widest spread, flat and patterned sets.
    directed_rows = '{
      '{16'hFFFF, 1'b1, 1'b1, '{16'hFFFF, 31'd0, 16'd0, 1'b0}},
      '{16'h0000, 1'b1, 1'b1, '{16'h0000, 31'd0, 16'd0, 1'b0}},
      '{16'h0000, 1'b0, 1'b0, '0},
      '{16'hFFFF, 1'b1, 1'b1, '{16'd32767, 31'd1073709056, 16'd32767, 1'b0}},
      '{16'd1,    1'b0, 1'b0, '0},
      '{16'd2,    1'b0, 1'b0, '0},
      '{16'd3,    1'b1, 1'b0, '0},
      '{16'd100,  1'b0, 1'b0, '0},
      '{16'd200,  1'b0, 1'b0, '0},
      '{16'd300,  1'b0, 1'b0, '0},
      '{16'd400,  1'b1, 1'b0, '0},
      '{16'hFFFF, 1'b0, 1'b0, '0},
      '{16'hFFFF, 1'b0, 1'b0, '0},
      '{16'hFFFF, 1'b1, 1'b1, '{16'hFFFF, 31'd0, 16'd0, 1'b0}},
      '{16'h5555, 1'b0, 1'b0, '0},
      '{16'hAAAA, 1'b1, 1'b0, '0},
      '{16'h8000, 1'b0, 1'b0, '0},
      '{16'h7FFF, 1'b0, 1'b0, '0},
      '{16'h0001, 1'b0, 1'b0, '0},
      '{16'hFFFE, 1'b1, 1'b0, '0}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_sample(directed_rows[i].sample, directed_rows[i].last,
                  directed_rows[i].typed, directed_rows[i].want);
    drain_results();

    // Random sets; the first two fill the store past and exactly to its size.
    items_sent = 0;
    set_no = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (set_no == 0) set_size = STORE_DEPTH + 3;
      else if (set_no == 1) set_size = STORE_DEPTH;
      else if ($urandom_range(0, 19) == 0)
        set_size = $urandom_range(STORE_DEPTH - 2, STORE_DEPTH + 12);
      else set_size = $urandom_range(1, 12);
      flavor = $urandom_range(0, 3);
      base = $urandom_range(0, 65520);
      for (int i = 0; i < set_size; i++) begin
        calm = (items_sent > CALM_AFTER);
        send_sample(pick_sample(flavor, base), i == set_size - 1, 1'b0, '0);
      end
      if (!calm && $urandom_range(0, 7) == 0) drain_results();
      set_no++;
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
